// File: rtl/lkvc_pkg.sv
// Shared constants for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Operation codes carried on s_tuser
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // read_value returned by a get that misses
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Fully associative LRU key-value cache with a sequential entry scanner.
`timescale 1ns / 1ps
`default_nettype none

// Steps: lookup scan over the N entries in use, decision, recency update pass,
//   result into the output register (which waits while full and m_tready is low).
// One request at a time, taken in idle once the last result is in the output
//   register; a get miss or a first insert into an empty cache skips the update
//   pass. Each pass reads one entry per cycle; the scan has one key comparator.
// Reset: aresetn (synchronous, active low) empties the cache, sets capacity to 16
//   and drops any pending result. No clearing pass; the block is ready at once.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire               aclk,
    input  wire               aresetn,

    // Configuration: capacity register
    input  wire               cfg_wr_en,
    input  wire  [CAP_W-1:0]  cfg_wr_data,

    // Request channel
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [63:0]       s_tdata,     // [31:0] key, [63:32] value
    input  wire               s_tuser,     // [0] func (0 get, 1 set)

    // Result channel
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [31:0]       m_tdata,     // [31:0] read_value
    output logic [1:0]        m_tuser      // [0] hit, [1] evicted
);

    // Index, rank and count widths
    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,     // walk valid entries: key match and LRU slot
        ST_DECIDE,   // choose target, write key/value on a set, reset target rank
        ST_UPDATE,   // walk valid entries again and age ranks
        ST_RESULT    // hand result to the output register
    } state_t;

    // Entry storage. Valid entries always occupy slots 0..count-1, since slots
    // fill in order and nothing is ever removed, so no per-entry valid bits.
    logic [KEY_W-1:0] key_mem  [ENTRIES];
    logic [VAL_W-1:0] val_mem  [ENTRIES];
    logic [RW-1:0]    rank_mem [ENTRIES];

    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [RW-1:0]    rank_rd_reg;

    // Control and datapath registers
    state_t           state_reg,      state_next;
    logic [CW-1:0]    count_reg,      count_next;
    logic [CAP_W-1:0] cap_reg,        cap_next;
    logic             func_reg,       func_next;
    logic [KEY_W-1:0] key_reg,        key_next;
    logic [VAL_W-1:0] val_reg,        val_next;
    logic [CW-1:0]    lim_reg,        lim_next;
    logic [CW-1:0]    rd_idx_reg,     rd_idx_next;
    logic             rd_vld_reg,     rd_vld_next;
    logic [IW-1:0]    rd_at_reg,      rd_at_next;
    logic             match_reg,      match_next;
    logic [IW-1:0]    match_slot_reg, match_slot_next;
    logic [VAL_W-1:0] match_val_reg,  match_val_next;
    logic [RW-1:0]    match_rank_reg, match_rank_next;
    logic [IW-1:0]    lru_slot_reg,   lru_slot_next;
    logic [IW-1:0]    tgt_reg,        tgt_next;
    logic [CW-1:0]    old_rank_reg,   old_rank_next;
    logic             res_hit_reg,    res_hit_next;
    logic [VAL_W-1:0] res_val_reg,    res_val_next;
    logic             res_ev_reg,     res_ev_next;
    logic             m_tvalid_reg,   m_tvalid_next;
    logic             m_hit_reg,      m_hit_next;
    logic [VAL_W-1:0] m_val_reg,      m_val_next;
    logic             m_ev_reg,       m_ev_next;

    // Memory port controls
    logic [IW-1:0]    rd_addr;
    logic             kv_we;
    logic [IW-1:0]    kv_wa;
    logic             rank_we;
    logic [IW-1:0]    rank_wa;
    logic [RW-1:0]    rank_wd;

    logic             issue;
    logic [CMPW-1:0]  cap_eff;
    logic             room;
    logic             in_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_val_reg;
    assign m_tuser  = {m_ev_reg, m_hit_reg};

    assign rd_addr  = rd_idx_reg[IW-1:0];
    assign issue    = (rd_idx_reg < lim_reg);

    // Capacity clamped to 1..ENTRIES
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CMPW'(1);
        end else if (CMPW'(cap_reg) > CMPW'(ENTRIES)) begin
            cap_eff = CMPW'(ENTRIES);
        end else begin
            cap_eff = CMPW'(cap_reg);
        end
    end
    assign room = (CMPW'(count_reg) < cap_eff);

    // Entry memories: one read and one write per cycle, registered read
    always_ff @(posedge aclk) begin
        if (kv_we) begin
            key_mem[kv_wa] <= key_reg;
            val_mem[kv_wa] <= val_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd_reg <= rank_mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        lim_next        = lim_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        rd_at_next      = rd_at_reg;
        match_next      = match_reg;
        match_slot_next = match_slot_reg;
        match_val_next  = match_val_reg;
        match_rank_next = match_rank_reg;
        lru_slot_next   = lru_slot_reg;
        tgt_next        = tgt_reg;
        old_rank_next   = old_rank_reg;
        res_hit_next    = res_hit_reg;
        res_val_next    = res_val_reg;
        res_ev_next     = res_ev_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_hit_next      = m_hit_reg;
        m_val_next      = m_val_reg;
        m_ev_next       = m_ev_reg;
        kv_we           = 1'b0;
        kv_wa           = tgt_reg;
        rank_we         = 1'b0;
        rank_wa         = rd_at_reg;
        rank_wd         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    func_next   = s_tuser;
                    key_next    = s_tdata[31:0];
                    val_next    = s_tdata[63:32];
                    lim_next    = count_reg;
                    rd_idx_next = '0;
                    match_next  = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (rd_vld_reg) begin
                    if (key_rd_reg == key_reg) begin
                        match_next      = 1'b1;
                        match_slot_next = rd_at_reg;
                        match_val_next  = val_rd_reg;
                        match_rank_next = rank_rd_reg;
                    end
                    if (CW'(rank_rd_reg) == lim_reg - CW'(1)) begin
                        lru_slot_next = rd_at_reg;
                    end
                end
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_at_next  = rd_addr;
                end else begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                res_hit_next = match_reg;
                res_ev_next  = 1'b0;
                state_next   = ST_RESULT;
                if (match_reg) begin
                    // hit: refresh, set overwrites value
                    res_val_next  = (func_reg == FUNC_SET) ? val_reg : match_val_reg;
                    tgt_next      = match_slot_reg;
                    old_rank_next = CW'(match_rank_reg);
                    kv_we         = (func_reg == FUNC_SET);
                    kv_wa         = match_slot_reg;
                    rank_we       = 1'b1;
                    rank_wa       = match_slot_reg;
                    if (lim_reg != '0) begin
                        state_next = ST_UPDATE;
                    end
                end else if (func_reg == FUNC_GET) begin
                    res_val_next = MISS_VALUE;
                end else if (room) begin
                    // insert into next free slot; every valid entry ages
                    res_val_next  = val_reg;
                    tgt_next      = count_reg[IW-1:0];
                    old_rank_next = count_reg;
                    count_next    = count_reg + CW'(1);
                    kv_we         = 1'b1;
                    kv_wa         = count_reg[IW-1:0];
                    rank_we       = 1'b1;
                    rank_wa       = count_reg[IW-1:0];
                    if (lim_reg != '0) begin
                        state_next = ST_UPDATE;
                    end
                end else begin
                    // full: replace the least recently used entry
                    res_val_next  = val_reg;
                    res_ev_next   = 1'b1;
                    tgt_next      = lru_slot_reg;
                    old_rank_next = lim_reg - CW'(1);
                    kv_we         = 1'b1;
                    kv_wa         = lru_slot_reg;
                    rank_we       = 1'b1;
                    rank_wa       = lru_slot_reg;
                    state_next    = ST_UPDATE;
                end
                rd_idx_next = '0;
            end

            ST_UPDATE: begin
                if (rd_vld_reg && (rd_at_reg != tgt_reg) &&
                    (CW'(rank_rd_reg) < old_rank_reg)) begin
                    rank_we = 1'b1;
                    rank_wa = rd_at_reg;
                    rank_wd = rank_rd_reg + RW'(1);
                end
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_at_next  = rd_addr;
                end else begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = res_hit_reg;
                    m_val_next    = res_val_reg;
                    m_ev_next     = res_ev_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg       <= func_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        lim_reg        <= lim_next;
        rd_idx_reg     <= rd_idx_next;
        rd_at_reg      <= rd_at_next;
        match_reg      <= match_next;
        match_slot_reg <= match_slot_next;
        match_val_reg  <= match_val_next;
        match_rank_reg <= match_rank_next;
        lru_slot_reg   <= lru_slot_next;
        tgt_reg        <= tgt_next;
        old_rank_reg   <= old_rank_next;
        res_hit_reg    <= res_hit_next;
        res_val_reg    <= res_val_next;
        res_ev_reg     <= res_ev_next;
        m_hit_reg      <= m_hit_next;
        m_val_reg      <= m_val_next;
        m_ev_reg       <= m_ev_next;
    end

    // Fill never exceeds the entry count
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= CMPW'(ENTRIES))
        else $error("entry count above ENTRIES");

    // Fill grows by at most one per step and never shrinks
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> (count_reg == $past(count_reg)) ||
                    (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count jumped");

    // An eviction is never a hit and needs a non-empty cache
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (count_reg != '0)))
        else $error("bad eviction result");

    // One item at a time: no second transfer right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // Rank memory written only in the decision and update steps
    a_rank_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        rank_we |-> ((state_reg == ST_DECIDE) || (state_reg == ST_UPDATE)))
        else $error("stray rank write");

endmodule

`default_nettype wire
